[src/complex_arithmetic_unit_top_defines.svh]
// Assertion macros shared by the complex arithmetic unit modules.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cau_pkg.sv]
// Package with widths, opcodes and the issued-item type of the complex arithmetic unit.
package cau_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int OpWidth   = 4;
    localparam int ProdWidth = 2 * DataWidth;
    // Widest intermediate: numerator of a complex divide shifted left.
    localparam int WideWidth = 2 * DataWidth + 2 + FracBits;
    localparam int QDepth    = 4;
    localparam int QPtrWidth = $clog2(QDepth);

    localparam logic [OpWidth-1:0] OP_CONJ      = 4'd0;
    localparam logic [OpWidth-1:0] OP_ADD       = 4'd1;
    localparam logic [OpWidth-1:0] OP_ADD3      = 4'd2;
    localparam logic [OpWidth-1:0] OP_SUB       = 4'd3;
    localparam logic [OpWidth-1:0] OP_MUL       = 4'd4;
    localparam logic [OpWidth-1:0] OP_DIV       = 4'd5;
    localparam logic [OpWidth-1:0] OP_SCALE     = 4'd6;
    localparam logic [OpWidth-1:0] OP_DIVREAL   = 4'd7;
    localparam logic [OpWidth-1:0] OP_ADDREAL   = 4'd8;
    localparam logic [OpWidth-1:0] OP_SUBREAL   = 4'd9;
    localparam logic [OpWidth-1:0] OP_REALMINUS = 4'd10;

    typedef logic signed [DataWidth-1:0] data_t;
    typedef logic signed [WideWidth-1:0] wide_t;

    // Classified item as it leaves the front end.
    typedef struct packed {
        logic  is_div;   // result comes from the divider
        logic  dz;       // divisor is zero
        logic  valid_op; // opcode defined
        data_t a_re;
        data_t a_im;
        wide_t re;       // exact pre-saturation value or divide numerator
        wide_t im;
        wide_t den;      // divisor, positive only by sign handling in back end
    } item_t;

    localparam int ItemWidth = $bits(item_t);
endpackage

[src/cau_ram.sv]
// Generic one-write, one-read RAM with registered read data.
module cau_ram #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[src/cau_front.sv]
// Front end: decodes the opcode and forms exact sums, products and divide operands.
module cau_front
    import cau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OpWidth-1:0]   op,
    input  data_t                a_re,
    input  data_t                a_im,
    input  data_t                b_re,
    input  data_t                b_im,
    input  data_t                c_re,
    input  data_t                c_im,
    input  data_t                scalar,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_item
);
    // Stage 1: register operands and the four products.
    logic                      s1_valid_reg;
    logic [OpWidth-1:0]        op_reg;
    data_t                     ar_reg, ai_reg, br_reg, bi_reg, cr_reg, ci_reg, s_reg;
    logic signed [ProdWidth-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [ProdWidth-1:0] p0_next, p1_next, p2_next, p3_next;
    logic                      s2_valid_reg;
    item_t                     item_reg, item_next;
    logic                      s1_ready, s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Product pairs chosen by opcode, one multiplier each.
    always_comb
    begin
        p0_next = ProdWidth'(a_re) * ProdWidth'(b_re);
        p1_next = ProdWidth'(a_im) * ProdWidth'(b_im);
        p2_next = ProdWidth'(a_re) * ProdWidth'(b_im);
        p3_next = ProdWidth'(a_im) * ProdWidth'(b_re);
        case (op)
            OP_DIV:
            begin
                p2_next = ProdWidth'(b_re) * ProdWidth'(b_re);
                p3_next = ProdWidth'(b_im) * ProdWidth'(b_im);
                p0_next = ProdWidth'(a_re) * ProdWidth'(b_re);
                p1_next = ProdWidth'(a_im) * ProdWidth'(b_im);
            end
            OP_SCALE:
            begin
                p0_next = ProdWidth'(scalar) * ProdWidth'(a_re);
                p1_next = ProdWidth'(scalar) * ProdWidth'(a_im);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            op_reg <= op;
            ar_reg <= a_re;
            ai_reg <= a_im;
            br_reg <= b_re;
            bi_reg <= b_im;
            cr_reg <= c_re;
            ci_reg <= c_im;
            s_reg  <= scalar;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    // The divide's cross products ai*br and ar*bi need a second pass; they
    // are formed here from registered operands.
    logic signed [ProdWidth-1:0] x0, x1;
    assign x0 = ProdWidth'(ai_reg) * ProdWidth'(br_reg);
    assign x1 = ProdWidth'(ar_reg) * ProdWidth'(bi_reg);

    always_comb
    begin
        item_next          = '0;
        item_next.a_re     = ar_reg;
        item_next.a_im     = ai_reg;
        item_next.valid_op = 1'b1;
        item_next.den      = WideWidth'(1);
        case (op_reg)
            OP_CONJ:
            begin
                item_next.re = WideWidth'(ar_reg);
                item_next.im = -WideWidth'(ai_reg);
            end
            OP_ADD:
            begin
                item_next.re = WideWidth'(ar_reg) + WideWidth'(br_reg);
                item_next.im = WideWidth'(ai_reg) + WideWidth'(bi_reg);
            end
            OP_ADD3:
            begin
                item_next.re = WideWidth'(ar_reg) + WideWidth'(br_reg) + WideWidth'(cr_reg);
                item_next.im = WideWidth'(ai_reg) + WideWidth'(bi_reg) + WideWidth'(ci_reg);
            end
            OP_SUB:
            begin
                item_next.re = WideWidth'(ar_reg) - WideWidth'(br_reg);
                item_next.im = WideWidth'(ai_reg) - WideWidth'(bi_reg);
            end
            OP_MUL:
            begin
                item_next.re = (WideWidth'(p0_reg) - WideWidth'(p1_reg)) >>> FracBits;
                item_next.im = (WideWidth'(p2_reg) + WideWidth'(p3_reg)) >>> FracBits;
            end
            OP_DIV:
            begin
                item_next.is_div = 1'b1;
                item_next.dz     = (br_reg == '0) && (bi_reg == '0);
                item_next.re     = (WideWidth'(p0_reg) + WideWidth'(p1_reg)) <<< FracBits;
                item_next.im     = (WideWidth'(x0) - WideWidth'(x1)) <<< FracBits;
                item_next.den    = WideWidth'(p2_reg) + WideWidth'(p3_reg);
            end
            OP_SCALE:
            begin
                item_next.re = WideWidth'(p0_reg) >>> FracBits;
                item_next.im = WideWidth'(p1_reg) >>> FracBits;
            end
            OP_DIVREAL:
            begin
                item_next.is_div = 1'b1;
                item_next.dz     = (s_reg == '0);
                item_next.re     = WideWidth'(ar_reg) <<< FracBits;
                item_next.im     = WideWidth'(ai_reg) <<< FracBits;
                item_next.den    = WideWidth'(s_reg);
            end
            OP_ADDREAL:
            begin
                item_next.re = WideWidth'(ar_reg) + WideWidth'(s_reg);
                item_next.im = WideWidth'(ai_reg);
            end
            OP_SUBREAL:
            begin
                item_next.re = WideWidth'(ar_reg) - WideWidth'(s_reg);
                item_next.im = WideWidth'(ai_reg);
            end
            OP_REALMINUS:
            begin
                item_next.re = WideWidth'(s_reg) - WideWidth'(ar_reg);
                item_next.im = -WideWidth'(ai_reg);
            end
            default:
            begin
                item_next.valid_op = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = item_reg;
endmodule

[src/cau_queue.sv]
// Short queue between front and back end, built on the generic RAM.
module cau_queue
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);
    `include "complex_arithmetic_unit_top_defines.svh"

    logic [QPtrWidth-1:0] wptr_reg, rptr_reg;
    logic [QPtrWidth:0]   count_reg;
    logic                 rd_valid_reg;
    logic                 push, pop, fetch;
    logic [ItemWidth-1:0] rdata;

    // RAM output register acts as the head; fetch refills it and it holds otherwise.
    assign in_ready  = (count_reg != (QPtrWidth+1)'(QDepth));
    assign push      = in_valid && in_ready;
    assign pop       = rd_valid_reg && out_ready;
    assign fetch     = (count_reg != '0) && (!rd_valid_reg || pop);
    assign out_valid = rd_valid_reg;
    assign out_item  = item_t'(rdata);

    cau_ram #(.Width(ItemWidth), .Depth(QDepth)) u_ram (
        .clk  (clk),
        .we   (push),
        .waddr(wptr_reg),
        .wdata(ItemWidth'(in_item)),
        .re   (fetch),
        .raddr(rptr_reg),
        .rdata(rdata)
    );

    // count_reg counts entries still in the RAM array, not the head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (fetch)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPtrWidth+1)'(push) - (QPtrWidth+1)'(fetch);
            if (fetch)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    `CAU_ASSERT_IMP(a_no_overfill, 1'b1, count_reg <= (QPtrWidth+1)'(QDepth))
    `CAU_ASSERT_IMP(a_full_blocks, count_reg == (QPtrWidth+1)'(QDepth), !in_ready)
    `CAU_ASSERT_NEXT(a_fetch_valid, fetch, rd_valid_reg)
endmodule

[src/cau_back.sv]
// Back end: pipelined signed divider, saturation and the result register.
module cau_back
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t res_re,
    output data_t res_im,
    output logic  overflow,
    output logic  div_by_zero
);
    `include "complex_arithmetic_unit_top_defines.svh"

    localparam int Steps = WideWidth;
    localparam int UW    = WideWidth;

    typedef struct packed {
        logic           valid;
        logic           is_div;
        logic           dz;
        logic           valid_op;
        data_t          a_re;
        data_t          a_im;
        logic           neg_re;
        logic           neg_im;
        logic [UW-1:0]  n_re;   // dividend bits still to shift in, or plain value
        logic [UW-1:0]  n_im;
        logic [UW-1:0]  r_re;   // partial remainders
        logic [UW-1:0]  r_im;
        logic [UW-1:0]  d;      // divisor magnitude
    } stage_t;

    stage_t pipe_reg [Steps];
    stage_t pipe_next [Steps+1];
    logic   advance;
    logic   out_valid_reg;
    data_t  res_re_reg, res_im_reg;
    logic   ov_reg, dz_reg;

    // Whole pipeline moves together; it stalls only when the output is held.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    function automatic logic [UW-1:0] uabs(input wide_t v);
        uabs = v[UW-1] ? UW'(-v) : UW'(v);
    endfunction

    // Stage 0 loads magnitudes and signs for divides, and plain values otherwise.
    always_comb
    begin
        pipe_next[0]          = '0;
        pipe_next[0].valid    = in_valid;
        pipe_next[0].is_div   = in_item.is_div;
        pipe_next[0].dz       = in_item.dz;
        pipe_next[0].valid_op = in_item.valid_op;
        pipe_next[0].a_re     = in_item.a_re;
        pipe_next[0].a_im     = in_item.a_im;
        if (in_item.is_div)
        begin
            pipe_next[0].neg_re = in_item.re[UW-1] ^ in_item.den[UW-1];
            pipe_next[0].neg_im = in_item.im[UW-1] ^ in_item.den[UW-1];
            pipe_next[0].n_re   = uabs(in_item.re);
            pipe_next[0].n_im   = uabs(in_item.im);
            pipe_next[0].d      = uabs(in_item.den);
        end
        else
        begin
            pipe_next[0].n_re = UW'(in_item.re);
            pipe_next[0].n_im = UW'(in_item.im);
        end
    end

    // One restoring step per stage; quotient bits replace dividend bits.
    for (genvar k = 1; k <= Steps; k++)
    begin : g_step
        logic [UW:0] tre, tim;
        always_comb
        begin
            pipe_next[k] = pipe_reg[k-1];
            tre = '0;
            tim = '0;
            if (pipe_reg[k-1].is_div)
            begin
                tre = {pipe_reg[k-1].r_re, pipe_reg[k-1].n_re[UW-1]} - {1'b0, pipe_reg[k-1].d};
                tim = {pipe_reg[k-1].r_im, pipe_reg[k-1].n_im[UW-1]} - {1'b0, pipe_reg[k-1].d};
                pipe_next[k].r_re = tre[UW] ?
                    {pipe_reg[k-1].r_re[UW-2:0], pipe_reg[k-1].n_re[UW-1]} : tre[UW-1:0];
                pipe_next[k].r_im = tim[UW] ?
                    {pipe_reg[k-1].r_im[UW-2:0], pipe_reg[k-1].n_im[UW-1]} : tim[UW-1:0];
                pipe_next[k].n_re = {pipe_reg[k-1].n_re[UW-2:0], !tre[UW]};
                pipe_next[k].n_im = {pipe_reg[k-1].n_im[UW-2:0], !tim[UW]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Steps; k++)
            begin
                pipe_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < Steps; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // Final step output feeds sign fix and saturation directly.
    stage_t        fin;
    wide_t         vre, vim;
    logic          ovre, ovim;
    data_t         sre, sim;
    localparam wide_t MaxV = wide_t'({1'b0, {(DataWidth-1){1'b1}}});
    localparam wide_t MinV = -MaxV - wide_t'(1);

    assign fin = pipe_next[Steps];

    always_comb
    begin
        vre = wide_t'(fin.n_re);
        vim = wide_t'(fin.n_im);
        if (fin.is_div)
        begin
            vre = fin.neg_re ? -wide_t'(fin.n_re) : wide_t'(fin.n_re);
            vim = fin.neg_im ? -wide_t'(fin.n_im) : wide_t'(fin.n_im);
        end
        ovre = (vre > MaxV) || (vre < MinV);
        ovim = (vim > MaxV) || (vim < MinV);
        sre  = (vre > MaxV) ? data_t'(MaxV) : (vre < MinV) ? data_t'(MinV) : data_t'(vre);
        sim  = (vim > MaxV) ? data_t'(MaxV) : (vim < MinV) ? data_t'(MinV) : data_t'(vim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (fin.is_div && fin.dz)
            begin
                res_re_reg <= fin.a_re[DataWidth-1] ? data_t'(MinV) : data_t'(MaxV);
                res_im_reg <= fin.a_im[DataWidth-1] ? data_t'(MinV) : data_t'(MaxV);
                ov_reg     <= 1'b1;
                dz_reg     <= 1'b1;
            end
            else if (!fin.valid_op)
            begin
                res_re_reg <= '0;
                res_im_reg <= '0;
                ov_reg     <= 1'b0;
                dz_reg     <= 1'b0;
            end
            else
            begin
                res_re_reg <= sre;
                res_im_reg <= sim;
                ov_reg     <= ovre || ovim;
                dz_reg     <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_re      = res_re_reg;
    assign res_im      = res_im_reg;
    assign overflow    = ov_reg;
    assign div_by_zero = dz_reg;

    `CAU_ASSERT_IMP(a_dz_sets_ov, out_valid_reg && dz_reg, ov_reg)
    `CAU_ASSERT_NEXT(a_hold_stall, out_valid_reg && !out_ready, out_valid_reg && $stable(res_re_reg))
    `CAU_ASSERT_IMP(a_ready_rule, out_valid_reg && !out_ready, !in_ready)
endmodule

[src/complex_arithmetic_unit_top.sv]
// Top level of the complex arithmetic unit: streaming ports around front end, queue and back end.
// The unit takes one transaction per cycle and returns one result per transaction, in order.
// The edge that accepts a transaction loads the first of 87 registers on the path: two
// front-end stages (operand and product registers, then the exact wide sum), two in the
// four-entry queue (the RAM write, then its registered read), the divider's input stage and
// 81 step stages of the pipelined restoring divider, which makes one quotient bit per step
// over the 82-bit dividend with its last step formed just ahead of the saturating result
// register, and that result register itself. Every operation, not only the divides, flows
// through that divider pipeline, so ordering is kept without reordering logic. Throughput
// is one transaction per cycle; backpressure on the master side stalls the back end, then
// fills the queue, then stalls the front end.
module complex_arithmetic_unit_top
    import cau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0 up: a_re, a_im, b_re, b_im, c_re, c_im, scalar.
    input  logic [223:0] s_axis_tdata,
    // Field: op.
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0 up: res_re, res_im.
    output logic [63:0]  m_axis_tdata,
    // Fields from bit 0 up: overflow, div_by_zero.
    output logic [1:0]   m_axis_tuser
);
    logic  f_valid, f_ready, q_valid, q_ready;
    item_t f_item, q_item;
    data_t res_re, res_im;
    logic  overflow, div_by_zero;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .op       (s_axis_tuser),
        .a_re     (s_axis_tdata[31:0]),
        .a_im     (s_axis_tdata[63:32]),
        .b_re     (s_axis_tdata[95:64]),
        .b_im     (s_axis_tdata[127:96]),
        .c_re     (s_axis_tdata[159:128]),
        .c_im     (s_axis_tdata[191:160]),
        .scalar   (s_axis_tdata[223:192]),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_item (f_item)
    );

    cau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_item  (f_item),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_item (q_item)
    );

    cau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .res_re     (res_re),
        .res_im     (res_im),
        .overflow   (overflow),
        .div_by_zero(div_by_zero)
    );

    assign m_axis_tdata = {res_im, res_re};
    assign m_axis_tuser = {div_by_zero, overflow};
endmodule
